// ----- sv/usd_pkg.sv -----
// shared types, status codes and decode helpers for the utf8 stream decoder
// no dependencies; used by usd_decode, usd_rsp_queue and utf8_stream_decoder_core
`timescale 1ns / 1ps
`default_nettype none

package usd_pkg;

   // longest sequence a lead byte may announce
   localparam int MAX_SEQ_BYTES = 6;

   // result queue depth, at least two
   localparam int RSP_QUEUE_DEPTH_DEF = 4;

   localparam logic [30:0] REPLACEMENT_CHAR = 31'h0000FFFD;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_INVALID   = 3'd1;
   localparam logic [2:0] STATUS_BAD       = 3'd2;
   localparam logic [2:0] STATUS_SURROGATE = 3'd3;
   localparam logic [2:0] STATUS_NONCHAR   = 3'd4;
   localparam logic [2:0] STATUS_OVERLONG  = 3'd5;

   typedef struct packed {
      logic [2:0]  expected_length;
      logic [2:0]  bytes_seen;
      logic [30:0] accumulator;
   } dec_state_type;

   typedef struct packed {
      logic [30:0] code_point;
      logic [2:0]  result_status;
      logic        last_of_run;
   } result_type;

   // count of leading ones in a byte
   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] n;
      unique casez (b)
         8'b0???????: n = 4'd0;
         8'b10??????: n = 4'd1;
         8'b110?????: n = 4'd2;
         8'b1110????: n = 4'd3;
         8'b11110???: n = 4'd4;
         8'b111110??: n = 4'd5;
         8'b1111110?: n = 4'd6;
         8'b11111110: n = 4'd7;
         default:     n = 4'd8;
      endcase
      return n;
   endfunction

   // shortest encoding length for a code point
   function automatic logic [2:0] minimal_length(input logic [30:0] cp);
      logic [2:0] len;
      if (cp < 31'h80)
         len = 3'd1;
      else if (cp < 31'h800)
         len = 3'd2;
      else if (cp < 31'h10000)
         len = 3'd3;
      else if (cp < 31'h200000)
         len = 3'd4;
      else if (cp < 31'h4000000)
         len = 3'd5;
      else
         len = 3'd6;
      return len;
   endfunction

   // checks a finished sequence: range, surrogate, noncharacter, overlong
   function automatic logic [2:0] classify(input logic [30:0] cp, input logic [2:0] len);
      logic [2:0] st;
      if (cp > 31'h10FFFF)
         st = STATUS_BAD;
      else if (cp >= 31'hD800 && cp <= 31'hDFFF)
         st = STATUS_SURROGATE;
      else if ((cp >= 31'hFDD0 && cp <= 31'hFDEF) || cp[15:1] == 15'h7FFF)
         st = STATUS_NONCHAR;
      else if (minimal_length(cp) < len)
         st = STATUS_OVERLONG;
      else
         st = STATUS_OK;
      return st;
   endfunction

endpackage

`default_nettype wire

// ----- sv/utf8_stream_decoder_core.sv -----
// utf8 stream decoder: sequence state registers, decode step and result queue
// depends on usd_pkg, usd_decode and usd_rsp_queue
//
// Takes one byte of original UTF-8 per beat (sequences of up to six bytes,
// code points up to 31 bits) and returns decoded code points with a status:
// ok, invalid sequence, above 0x10FFFF, surrogate, noncharacter or overlong.
// Flagged sequences still carry their decoded value; invalid ones carry
// 0xFFFD. A byte that breaks an armed sequence gives an invalid result and is
// then decoded fresh, so one byte can give two results; last_of_run marks the
// final result of each byte. Input bytes are taken one per cycle: the whole
// decode of a byte is one combinational step from the sequence state
// registers into the result queue, so req_ready only drops when the result
// queue lacks room for two entries. Results leave at one per cycle while
// rsp_ready is high, so a byte that gives two results takes two output beats.
// The results of an accepted byte are written into the result queue registers.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_core #(
   parameter int RSP_QUEUE_DEPTH = usd_pkg::RSP_QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [30:0]      rsp_code_point,
   output logic [2:0]       rsp_result_status,
   output logic             rsp_last_of_run
);

   // sequence state: armed length, bytes taken, partial code point
   usd_pkg::dec_state_type state_ff, state_in;
   usd_pkg::dec_state_type step_state;
   usd_pkg::result_type    step_res0, step_res1;
   usd_pkg::result_type    head;
   logic [1:0]             step_count;
   logic [1:0]             push_count;
   logic                   req_beat;
   logic                   rsp_beat;
   logic                   room_for_two;

   assign req_ready = room_for_two;
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;

   usd_decode u_decode (
      .cur_state (state_ff),
      .in_byte   (req_in_byte),
      .nxt_state (step_state),
      .res0      (step_res0),
      .res1      (step_res1),
      .res_count (step_count)
   );

   // results only go in on an accepted beat
   assign push_count = req_beat ? step_count : 2'd0;

   always_comb begin
      state_in = state_ff;
      if (req_beat)
         state_in = step_state;
   end

   // control fields reset; accumulator is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.expected_length <= 3'd0;
         state_ff.bytes_seen      <= 3'd0;
      end else begin
         state_ff.expected_length <= state_in.expected_length;
         state_ff.bytes_seen      <= state_in.bytes_seen;
      end
      state_ff.accumulator <= state_in.accumulator;
   end

   usd_rsp_queue #(
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push0        (step_res0),
      .push1        (step_res1),
      .room_for_two (room_for_two),
      .pop          (rsp_beat),
      .head_valid   (rsp_valid),
      .head         (head)
   );

   assign rsp_code_point    = head.code_point;
   assign rsp_result_status = head.result_status;
   assign rsp_last_of_run   = head.last_of_run;

   // an armed sequence always has its lead byte counted and is not yet full
   a_state_consistent: assert property (@(posedge clock) disable iff (reset)
      state_ff.expected_length != 3'd0 |->
         state_ff.bytes_seen != 3'd0 && state_ff.bytes_seen < state_ff.expected_length)
      else $error("armed sequence with bad byte count");

   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.expected_length == 3'd0 |-> state_ff.bytes_seen == 3'd0)
      else $error("byte count held with no sequence armed");

   a_length_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.expected_length <= 3'(usd_pkg::MAX_SEQ_BYTES))
      else $error("armed length beyond limit");

   // the second result of a byte is queued together with the first
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_last_of_run |=> rsp_valid)
      else $error("run ended without its final result");

   a_invalid_replacement: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_status == usd_pkg::STATUS_INVALID |->
         rsp_code_point == usd_pkg::REPLACEMENT_CHAR)
      else $error("invalid result without replacement character");

endmodule

`default_nettype wire

// ----- sv/usd_decode.sv -----
// one decode step: current sequence state and one byte in, next state and
// up to two results out; purely combinational, uses usd_pkg
`timescale 1ns / 1ps
`default_nettype none

module usd_decode (
   input  var usd_pkg::dec_state_type cur_state,
   input  wire logic [7:0]            in_byte,
   output usd_pkg::dec_state_type     nxt_state,
   output usd_pkg::result_type        res0,
   output usd_pkg::result_type        res1,
   output logic [1:0]                 res_count
);

   logic [3:0]                lead_n;
   logic                      fresh_lead;
   logic                      armed;
   logic                      is_cont;
   logic [30:0]               acc_shift;
   logic [2:0]                seen_inc;
   logic [7:0]                lead_mask;
   usd_pkg::result_type       fresh_res;

   assign lead_n     = usd_pkg::lead_ones(in_byte);
   assign fresh_lead = (lead_n >= 4'd2) && (lead_n <= 4'(usd_pkg::MAX_SEQ_BYTES));
   assign armed      = (cur_state.expected_length != 3'd0) &&
                       (cur_state.bytes_seen < cur_state.expected_length);
   assign is_cont    = (in_byte[7:6] == 2'b10);
   assign acc_shift  = {cur_state.accumulator[24:0], in_byte[5:0]};
   assign seen_inc   = cur_state.bytes_seen + 3'd1;
   assign lead_mask  = 8'hFF >> (lead_n + 4'd1);

   // ascii passes through, any other non-lead byte is replaced
   always_comb begin
      if (!in_byte[7]) begin
         fresh_res.code_point    = {23'd0, in_byte};
         fresh_res.result_status = usd_pkg::STATUS_OK;
      end else begin
         fresh_res.code_point    = usd_pkg::REPLACEMENT_CHAR;
         fresh_res.result_status = usd_pkg::STATUS_INVALID;
      end
      fresh_res.last_of_run = 1'b1;
   end

   always_comb begin
      nxt_state = cur_state;
      res0      = fresh_res;
      res1      = fresh_res;
      res_count = 2'd0;
      if (armed && is_cont) begin
         nxt_state.accumulator = acc_shift;
         if (seen_inc == cur_state.expected_length) begin
            nxt_state.expected_length = 3'd0;
            nxt_state.bytes_seen      = 3'd0;
            res0.code_point    = acc_shift;
            res0.result_status = usd_pkg::classify(acc_shift, cur_state.expected_length);
            res0.last_of_run   = 1'b1;
            res_count          = 2'd1;
         end else begin
            nxt_state.bytes_seen = seen_inc;
         end
      end else begin
         nxt_state.expected_length = 3'd0;
         nxt_state.bytes_seen      = 3'd0;
         // broken sequence reports first, then the byte starts fresh
         if (armed) begin
            res0.code_point    = usd_pkg::REPLACEMENT_CHAR;
            res0.result_status = usd_pkg::STATUS_INVALID;
            res0.last_of_run   = 1'b0;
         end
         if (fresh_lead) begin
            nxt_state.expected_length = lead_n[2:0];
            nxt_state.bytes_seen      = 3'd1;
            nxt_state.accumulator     = {23'd0, in_byte & lead_mask};
            if (armed) begin
               res0.last_of_run = 1'b1;
               res_count        = 2'd1;
            end
         end else if (armed) begin
            res_count = 2'd2;
         end else begin
            res_count = 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/usd_rsp_queue.sv -----
// result queue: takes up to two results a cycle, hands out one a cycle on each pop
// uses usd_pkg for the result type
`timescale 1ns / 1ps
`default_nettype none

module usd_rsp_queue #(
   parameter int DEPTH = usd_pkg::RSP_QUEUE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          push_count,
   input  var usd_pkg::result_type  push0,
   input  var usd_pkg::result_type  push1,
   output logic                     room_for_two,
   input  wire logic                pop,
   output logic                     head_valid,
   output usd_pkg::result_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   usd_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    wr_ptr_p1;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(DEPTH - 1))
         n = '0;
      else
         n = p + PTR_W'(1);
      return n;
   endfunction

   assign wr_ptr_p1    = ptr_next(wr_ptr_ff);
   assign head_valid   = (count_ff != '0);
   assign head         = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_count == 2'd1)
         wr_ptr_in = wr_ptr_p1;
      else if (push_count == 2'd2)
         wr_ptr_in = ptr_next(wr_ptr_p1);
      if (pop)
         rd_ptr_in = ptr_next(rd_ptr_ff);
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0)
         entry_ff[wr_ptr_ff] <= push0;
      if (push_count == 2'd2)
         entry_ff[wr_ptr_p1] <= push1;
   end

endmodule

`default_nettype wire
